@@ rtl/tlex_pkg.sv @@
// shared types and constants of the token lexer
// no dependencies
`default_nettype none
package tlex_pkg;

  typedef enum logic [3:0] {
    M_IDLE  = 4'd0,
    M_PAIR  = 4'd1,
    M_SLASH = 4'd2,
    M_LCOMM = 4'd3,
    M_BCOMM = 4'd4,
    M_BSTAR = 4'd5,
    M_STR   = 4'd6,
    M_INT   = 4'd7,
    M_DOT   = 4'd8,
    M_FRAC  = 4'd9,
    M_IDENT = 4'd10
  } mode_t;

  localparam logic [1:0] CMD_BYTE  = 2'd0;
  localparam logic [1:0] CMD_END   = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;

  localparam logic [5:0] K_DOT    = 6'd9;
  localparam logic [5:0] K_SLASH  = 6'd15;
  localparam logic [5:0] K_IDENT  = 6'd32;
  localparam logic [5:0] K_STRING = 6'd33;
  localparam logic [5:0] K_NUMBER = 6'd34;
  localparam logic [5:0] K_SYMBOL = 6'd35;
  localparam logic [5:0] K_EOF    = 6'd36;
  localparam logic [5:0] K_KW0    = 6'd37;
  localparam logic [3:0] KW_KIND_MAX = 4'd12;

  // one token leaving the front part; identifiers still need the table lookup
  typedef struct packed {
    logic [5:0]  kind;
    logic        is_ident;
    logic [63:0] ident;
    logic [3:0]  ident_count;
    logic        too_long;
    logic [23:0] start;
    logic [23:0] length;
    logic [23:0] line;
    logic        last;
  } tok_t;

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  // second byte, single kind, double kind for a pair opener
  function automatic logic [19:0] pair_info(input logic [7:0] c);
    case (c)
      "{":     return {8'h7b, 6'd2, 6'd30};
      "}":     return {8'h7d, 6'd3, 6'd31};
      "*":     return {8'h2a, 6'd14, 6'd29};
      "!":     return {8'h3d, 6'd19, 6'd20};
      "=":     return {8'h3d, 6'd21, 6'd22};
      "<":     return {8'h3d, 6'd18, 6'd24};
      ">":     return {8'h3d, 6'd17, 6'd23};
      "&":     return {8'h26, 6'd25, 6'd26};
      default: return {8'h7c, 6'd27, 6'd28};
    endcase
  endfunction

endpackage
`default_nettype wire

@@ rtl/tlex_front.sv @@
// scanner front part: per-byte state machine producing up to three tokens
// depends on tlex_pkg
`default_nettype none
module tlex_front #(
  parameter int MAX_KEYWORD_LEN = 8,
  parameter int POSITION_BITS   = 24
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 fire,
  input  wire logic [1:0]           command,
  input  wire logic [7:0]           char_code,
  output tlex_pkg::tok_t            tok [3],
  output logic [1:0]                tok_n
);
  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
  localparam logic [3:0] MKL = 4'(MAX_KEYWORD_LEN);

  tlex_pkg::mode_t          mode, mode_next;
  logic [7:0]               held, held_next;
  logic [POSITION_BITS-1:0] offs, offs_next, tstart, tstart_next, line, line_next;
  logic [63:0]              ibuf, ibuf_next;
  logic [3:0]               icnt, icnt_next;
  logic                     ilong, ilong_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= tlex_pkg::M_IDLE; held <= '0; offs <= '0; tstart <= '0;
      line <= POSITION_BITS'(1); ibuf <= '0; icnt <= '0; ilong <= 1'b0;
    end else if (fire) begin
      mode <= mode_next; held <= held_next; offs <= offs_next;
      tstart <= tstart_next; line <= line_next; ibuf <= ibuf_next;
      icnt <= icnt_next; ilong <= ilong_next;
    end
  end

  always_comb begin
    logic [7:0] c;
    logic [19:0] pi;
    logic [POSITION_BITS-1:0] pos, dot;
    logic flush, start;
    c = char_code;
    pos = offs;
    dot = (pos != '0) ? pos - 1'b1 : '0;
    pi = tlex_pkg::pair_info(held);
    mode_next = mode; held_next = held; tstart_next = tstart; line_next = line;
    ibuf_next = ibuf; icnt_next = icnt; ilong_next = ilong;
    offs_next = offs;
    tok_n = 2'd0;
    flush = 1'b0; start = 1'b0;
    for (int k = 0; k < 3; k++) tok[k] = '0;

    // local emit helper is unrolled by hand through tok_n
    if (command == tlex_pkg::CMD_BYTE) begin
      if (offs != POS_MAX) offs_next = offs + 1'b1;
      case (mode)
        tlex_pkg::M_PAIR: begin
          if (c == pi[19:12]) begin
            tok[0].kind = pi[5:0]; tok[0].start = 24'(tstart); tok[0].length = 24'd2;
            tok[0].line = 24'(line); tok_n = 2'd1; mode_next = tlex_pkg::M_IDLE;
          end else begin
            flush = 1'b1;
          end
        end
        tlex_pkg::M_SLASH: begin
          if (c == "/") mode_next = tlex_pkg::M_LCOMM;
          else if (c == "*") mode_next = tlex_pkg::M_BCOMM;
          else flush = 1'b1;
        end
        tlex_pkg::M_LCOMM: begin
          if (c == 8'h0a) begin mode_next = tlex_pkg::M_IDLE; flush = 1'b1; end
        end
        tlex_pkg::M_BCOMM: begin
          if (c == "*") mode_next = tlex_pkg::M_BSTAR;
          else if (c == 8'h0a && line != POS_MAX) line_next = line + 1'b1;
        end
        tlex_pkg::M_BSTAR: begin
          if (c == "/") mode_next = tlex_pkg::M_IDLE;
          else if (c != "*") begin
            mode_next = tlex_pkg::M_BCOMM;
            if (c == 8'h0a && line != POS_MAX) line_next = line + 1'b1;
          end
        end
        tlex_pkg::M_STR: begin
          if (c == held) begin
            tok[0].kind = tlex_pkg::K_STRING;
            tok[0].start = 24'(tstart + 1'b1);
            tok[0].length = (pos > tstart) ? 24'(pos - tstart - 1'b1) : 24'd0;
            tok[0].line = 24'(line); tok_n = 2'd1; mode_next = tlex_pkg::M_IDLE;
          end else if (c == 8'h0a && line != POS_MAX) begin
            line_next = line + 1'b1;
          end
        end
        tlex_pkg::M_INT: begin
          if (c == ".") mode_next = tlex_pkg::M_DOT;
          else if (!tlex_pkg::is_digit(c)) flush = 1'b1;
        end
        tlex_pkg::M_DOT: begin
          if (tlex_pkg::is_digit(c)) mode_next = tlex_pkg::M_FRAC;
          else flush = 1'b1;
        end
        tlex_pkg::M_FRAC: begin
          if (!tlex_pkg::is_digit(c)) flush = 1'b1;
        end
        tlex_pkg::M_IDENT: begin
          if (tlex_pkg::is_alpha(c) || tlex_pkg::is_digit(c) || c == "_") begin
            if (icnt < MKL) begin
              ibuf_next = ibuf | (64'(c) << {icnt[2:0], 3'b000});
              icnt_next = icnt + 1'b1;
            end else begin
              ilong_next = 1'b1;
            end
          end else begin
            flush = 1'b1;
          end
        end
        default: flush = 1'b1;
      endcase
      start = flush;
    end else if (command == tlex_pkg::CMD_END) begin
      flush = 1'b1;
    end

    if (flush) begin
      tok[0].start = 24'(tstart); tok[0].line = 24'(line);
      tok[1].line = 24'(line);
      case (mode)
        tlex_pkg::M_PAIR: begin
          tok[0].kind = pi[11:6]; tok[0].length = 24'd1; tok_n = 2'd1;
        end
        tlex_pkg::M_SLASH: begin
          tok[0].kind = tlex_pkg::K_SLASH; tok[0].length = 24'd1; tok_n = 2'd1;
        end
        tlex_pkg::M_INT, tlex_pkg::M_FRAC: begin
          tok[0].kind = tlex_pkg::K_NUMBER;
          tok[0].length = (pos > tstart) ? 24'(pos - tstart) : 24'd0; tok_n = 2'd1;
        end
        tlex_pkg::M_DOT: begin
          tok[0].kind = tlex_pkg::K_NUMBER;
          tok[0].length = (dot > tstart) ? 24'(dot - tstart) : 24'd0;
          tok[1].kind = tlex_pkg::K_DOT; tok[1].start = 24'(dot);
          tok[1].length = 24'd1; tok_n = 2'd2; tstart_next = dot;
        end
        tlex_pkg::M_IDENT: begin
          tok[0].kind = tlex_pkg::K_IDENT; tok[0].is_ident = 1'b1;
          tok[0].ident = ibuf; tok[0].ident_count = icnt; tok[0].too_long = ilong;
          tok[0].length = (pos > tstart) ? 24'(pos - tstart) : 24'd0; tok_n = 2'd1;
        end
        default: ;
      endcase
      mode_next = tlex_pkg::M_IDLE;
    end

    if (start) begin
      tstart_next = pos;
      tok[tok_n].start = 24'(pos); tok[tok_n].length = 24'd1;
      tok[tok_n].line = 24'(line);
      case (c)
        "(": begin tok[tok_n].kind = 6'd0;  tok_n = tok_n + 1'b1; end
        ")": begin tok[tok_n].kind = 6'd1;  tok_n = tok_n + 1'b1; end
        "[": begin tok[tok_n].kind = 6'd4;  tok_n = tok_n + 1'b1; end
        "]": begin tok[tok_n].kind = 6'd5;  tok_n = tok_n + 1'b1; end
        "@": begin tok[tok_n].kind = 6'd6;  tok_n = tok_n + 1'b1; end
        ":": begin tok[tok_n].kind = 6'd7;  tok_n = tok_n + 1'b1; end
        ";": begin tok[tok_n].kind = 6'd8;  tok_n = tok_n + 1'b1; end
        ".": begin tok[tok_n].kind = tlex_pkg::K_DOT; tok_n = tok_n + 1'b1; end
        "?": begin tok[tok_n].kind = 6'd10; tok_n = tok_n + 1'b1; end
        ",": begin tok[tok_n].kind = 6'd11; tok_n = tok_n + 1'b1; end
        "+": begin tok[tok_n].kind = 6'd12; tok_n = tok_n + 1'b1; end
        "-": begin tok[tok_n].kind = 6'd13; tok_n = tok_n + 1'b1; end
        "%": begin tok[tok_n].kind = 6'd16; tok_n = tok_n + 1'b1; end
        "{", "}", "*", "!", "=", "<", ">", "&", "|": begin
          mode_next = tlex_pkg::M_PAIR; held_next = c;
        end
        " ", 8'h0d, 8'h09: ;
        8'h0a: if (line != POS_MAX) line_next = line + 1'b1;
        "/": mode_next = tlex_pkg::M_SLASH;
        8'h22, 8'h27: begin mode_next = tlex_pkg::M_STR; held_next = c; end
        default: begin
          if (tlex_pkg::is_digit(c)) begin
            mode_next = tlex_pkg::M_INT;
          end else if (tlex_pkg::is_alpha(c) || c == "_") begin
            mode_next = tlex_pkg::M_IDENT; ibuf_next = 64'(c);
            icnt_next = 4'd1; ilong_next = 1'b0;
          end else begin
            tok[tok_n].kind = tlex_pkg::K_SYMBOL; tok_n = tok_n + 1'b1;
          end
        end
      endcase
    end

    if (command == tlex_pkg::CMD_END) begin
      tok[tok_n].kind = tlex_pkg::K_EOF;
      tok[tok_n].start = 24'(tstart_next);
      tok[tok_n].length = 24'd0;
      tok[tok_n].line = 24'(line);
      tok_n = tok_n + 1'b1;
      mode_next = tlex_pkg::M_IDLE; held_next = '0; offs_next = '0; tstart_next = '0;
      line_next = POSITION_BITS'(1); ibuf_next = '0; icnt_next = '0; ilong_next = 1'b0;
    end
    if (tok_n != 2'd0) tok[tok_n - 1'b1].last = 1'b1;
  end
endmodule
`default_nettype wire

@@ rtl/tlex_queue.sv @@
// token queue between front and back parts, up to three writes per cycle
// depends on tlex_pkg
`default_nettype none
module tlex_queue #(
  parameter int DEPTH_LOG = 3
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic [1:0]     wr_n,
  input  tlex_pkg::tok_t      wr_tok [3],
  output logic                has_room,
  input  wire logic           rd,
  output logic                rd_valid,
  output tlex_pkg::tok_t      rd_tok
);
  localparam int DEPTH = 1 << DEPTH_LOG;

  tlex_pkg::tok_t        store [DEPTH];
  logic [DEPTH_LOG-1:0]  wp, rp;
  logic [DEPTH_LOG:0]    cnt;

  assign rd_valid = cnt != '0;
  assign rd_tok   = store[rp];
  assign has_room = cnt <= (DEPTH_LOG+1)'(DEPTH - 3);

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++)
      if (2'(k) < wr_n) store[wp + DEPTH_LOG'(k)] <= wr_tok[k];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0;
    end else begin
      wp <= wp + DEPTH_LOG'(wr_n);
      rp <= rp + DEPTH_LOG'(rd && rd_valid);
      cnt <= cnt + (DEPTH_LOG+1)'(wr_n) - (DEPTH_LOG+1)'(rd && rd_valid);
    end
  end
endmodule
`default_nettype wire

@@ rtl/tlex_back.sv @@
// back part: keyword table, parallel lookup and output register
// depends on tlex_pkg
`default_nettype none
module tlex_back #(
  parameter int NUM_KEYWORDS    = 16,
  parameter int MAX_KEYWORD_LEN = 8
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           kw_we,
  input  wire logic [3:0]     kw_slot,
  input  wire logic [63:0]    kw_text,
  input  wire logic [3:0]     kw_length,
  input  wire logic [3:0]     kw_kind,
  input  wire logic           in_valid,
  input  tlex_pkg::tok_t      in_tok,
  output logic                in_take,
  output logic                out_valid,
  input  wire logic           out_pop,
  output tlex_pkg::tok_t      out_tok
);
  localparam int SLOT_BITS = (NUM_KEYWORDS > 1) ? $clog2(NUM_KEYWORDS) : 1;

  logic [63:0] ktext [NUM_KEYWORDS];
  logic [3:0]  kkind [NUM_KEYWORDS];
  logic [3:0]  klen  [NUM_KEYWORDS];
  logic [5:0]  kind_hit;
  logic [SLOT_BITS-1:0] wslot;
  tlex_pkg::tok_t hit_tok;

  assign wslot = SLOT_BITS'(kw_slot);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < NUM_KEYWORDS; s++) klen[s] <= '0;
    end else if (kw_we && 32'(kw_slot) < NUM_KEYWORDS) begin
      klen[wslot] <= kw_length;
    end
  end
  always_ff @(posedge clk) begin
    if (kw_we && 32'(kw_slot) < NUM_KEYWORDS) begin
      ktext[wslot] <= kw_text;
      kkind[wslot] <= kw_kind;
    end
  end

  // lowest matching slot wins
  always_comb begin
    logic [63:0] mask;
    kind_hit = in_tok.kind;
    for (int s = NUM_KEYWORDS - 1; s >= 0; s--) begin
      mask = '1;
      for (int b = 0; b < 8; b++) if (4'(b) >= klen[s]) mask[b*8 +: 8] = 8'h00;
      if (in_tok.is_ident && klen[s] != '0 && klen[s] <= 4'(MAX_KEYWORD_LEN) &&
          kkind[s] <= tlex_pkg::KW_KIND_MAX && !in_tok.too_long &&
          in_tok.ident_count == klen[s] && (ktext[s] & mask) == in_tok.ident)
        kind_hit = tlex_pkg::K_KW0 + 6'(kkind[s]);
    end
  end

  always_comb begin
    hit_tok = in_tok;
    hit_tok.kind = kind_hit;
  end

  assign in_take = in_valid && (!out_valid || out_pop);

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (in_take) out_valid <= 1'b1;
    else if (out_pop) out_valid <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (in_take) out_tok <= hit_tok;
  end
endmodule
`default_nettype wire

@@ rtl/token_lexer_with_keyword_table_core.sv @@
// top level of the token lexer: front scanner, token queue, keyword back part
// depends on tlex_pkg, tlex_front, tlex_queue, tlex_back
`default_nettype none
// streaming lexer taking one request per cycle: source bytes, an end mark, or
// keyword table writes. each byte request produces zero to three tokens, the
// end mark up to three; the front scanner handles one request a cycle and
// stalls (full high) while the eight-entry token queue lacks room for three
// more tokens, and holds off a table write while tokens still wait in the
// queue so that every identifier is looked up against the table as it stood
// when the identifier ended. throughput is one request per cycle while the
// consumer keeps pace with the token rate. keyword lookup over all slots is
// combinational in the back part, which holds the result register.
// a token completed by an accepted byte is written into the token queue and
// reaches the result ports through the back part's output register.
module token_lexer_with_keyword_table_core #(
  parameter int NUM_KEYWORDS    = 16,
  parameter int MAX_KEYWORD_LEN = 8,
  parameter int POSITION_BITS   = 24
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  command,
  input  wire logic [7:0]  char_code,
  input  wire logic [3:0]  kw_slot,
  input  wire logic [63:0] kw_text,
  input  wire logic [3:0]  kw_length,
  input  wire logic [3:0]  kw_kind,
  output logic             empty,
  input  wire logic        pop,
  output logic [5:0]       token_kind,
  output logic [23:0]      text_start,
  output logic [23:0]      text_length,
  output logic [23:0]      line_number,
  output logic             last_of_run
);
  tlex_pkg::tok_t ftok [3];
  logic [1:0]     ftok_n;
  logic           room, fire, qvalid, qtake, ovalid;
  tlex_pkg::tok_t qtok, otok;

  // request accepted
  assign fire = push && !full;
  // table writes wait until no token is left awaiting lookup
  assign full = !room || (command == tlex_pkg::CMD_WRITE && qvalid);

  tlex_front #(.MAX_KEYWORD_LEN(MAX_KEYWORD_LEN), .POSITION_BITS(POSITION_BITS)) u_front (
    .clk, .rst, .fire, .command, .char_code, .tok(ftok), .tok_n(ftok_n)
  );

  tlex_queue u_queue (
    .clk, .rst, .wr_n(fire ? ftok_n : 2'd0), .wr_tok(ftok), .has_room(room),
    .rd(qtake), .rd_valid(qvalid), .rd_tok(qtok)
  );

  tlex_back #(.NUM_KEYWORDS(NUM_KEYWORDS), .MAX_KEYWORD_LEN(MAX_KEYWORD_LEN)) u_back (
    .clk, .rst, .kw_we(fire && command == tlex_pkg::CMD_WRITE), .kw_slot, .kw_text,
    .kw_length, .kw_kind, .in_valid(qvalid), .in_tok(qtok), .in_take(qtake),
    .out_valid(ovalid), .out_pop(pop), .out_tok(otok)
  );

  assign empty       = !ovalid;
  assign token_kind  = otok.kind;
  assign text_start  = otok.start;
  assign text_length = otok.length;
  assign line_number = otok.line;
  assign last_of_run = otok.last;
endmodule
`default_nettype wire

@@ tb/testbench.sv @@
// self-checking testbench for token_lexer_with_keyword_table_core
// depends on tlex_pkg and the lexer rtl; holds its own scanner predictor
`default_nettype none
module testbench;
  import tlex_pkg::*;

  localparam int N_ITEMS  = 380;
  localparam int WD_LIMIT = 2000;
  localparam int DRAIN    = 20;
  localparam logic [1:0] CMD_SPARE = 2'd3;

  // one request as driven on the input ports
  typedef struct {
    logic [1:0]  cmd;
    logic [7:0]  ch;
    logic [3:0]  slot;
    logic [63:0] text;
    logic [3:0]  len;
    logic [3:0]  kind;
  } lex_req_t;

  // one token as it leaves the block
  typedef struct {
    logic [5:0]  kind;
    logic [23:0] start;
    logic [23:0] length;
    logic [23:0] line;
    logic        last;
  } lex_tok_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        pop = 1'b0;
  logic [1:0]  command = CMD_BYTE;
  logic [7:0]  char_code = 8'd0;
  logic [3:0]  kw_slot = 4'd0;
  logic [63:0] kw_text = 64'd0;
  logic [3:0]  kw_length = 4'd0;
  logic [3:0]  kw_kind = 4'd0;
  wire         full, empty, last_of_run;
  wire  [5:0]  token_kind;
  wire  [23:0] text_start, text_length, line_number;

  token_lexer_with_keyword_table_core u_top (
    .clk(clk), .rst(rst), .push(push), .full(full), .command(command),
    .char_code(char_code), .kw_slot(kw_slot), .kw_text(kw_text),
    .kw_length(kw_length), .kw_kind(kw_kind), .empty(empty), .pop(pop),
    .token_kind(token_kind), .text_start(text_start), .text_length(text_length),
    .line_number(line_number), .last_of_run(last_of_run)
  );

  always #4 clk = ~clk;

  lex_req_t pending_reqs[$];
  lex_tok_t expected_toks[$];
  lex_tok_t step_toks[$];
  int       n_sent = 0;
  int       n_errors = 0;
  int       quiet_cycles = 0;
  bit       req_taken = 1'b0;

  // scanner state of the predictor
  mode_t       sc_mode;
  logic [7:0]  sc_held;
  logic [23:0] sc_offset, sc_tstart, sc_line;
  logic [63:0] sc_ibuf;
  logic [3:0]  sc_icount;
  logic        sc_toolong;
  logic [63:0] kwt_text[16];
  logic [3:0]  kwt_len[16];
  logic [3:0]  kwt_kind[16];

  function automatic bit digit_ch(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit letter_ch(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic [23:0] span24(logic [23:0] a, logic [23:0] b);
    return b > a ? b - a : 24'd0;
  endfunction

  // pair openers: expected second byte, kind alone, kind as a pair
  task automatic pair_kinds(input logic [7:0] c, output logic [7:0] sec,
                            output logic [5:0] one, output logic [5:0] two);
    case (c)
      "{": begin sec = "{"; one = 6'd2;  two = 6'd30; end
      "}": begin sec = "}"; one = 6'd3;  two = 6'd31; end
      "*": begin sec = "*"; one = 6'd14; two = 6'd29; end
      "!": begin sec = "="; one = 6'd19; two = 6'd20; end
      "=": begin sec = "="; one = 6'd21; two = 6'd22; end
      "<": begin sec = "="; one = 6'd18; two = 6'd24; end
      ">": begin sec = "="; one = 6'd17; two = 6'd23; end
      "&": begin sec = "&"; one = 6'd25; two = 6'd26; end
      default: begin sec = "|"; one = 6'd27; two = 6'd28; end
    endcase
  endtask

  task automatic add_tok(input logic [5:0] k, input logic [23:0] s, input logic [23:0] l);
    lex_tok_t t;
    if (step_toks.size() < 3) begin
      t.kind = k; t.start = s; t.length = l; t.line = sc_line; t.last = 1'b0;
      step_toks.insert(step_toks.size(), t);
    end
  endtask

  task automatic next_line();
    if (sc_line != 24'hffffff) sc_line++;
  endtask

  task automatic clear_scan();
    sc_mode = M_IDLE; sc_held = 8'd0; sc_offset = 24'd0; sc_tstart = 24'd0;
    sc_line = 24'd1; sc_ibuf = 64'd0; sc_icount = 4'd0; sc_toolong = 1'b0;
  endtask

  // identifier or keyword: lowest matching valid slot wins
  task automatic add_word(input logic [23:0] stop);
    logic [5:0]  k;
    logic [63:0] mask;
    k = K_IDENT;
    for (int s = 0; s < 16; s++) begin
      if (k == K_IDENT && kwt_len[s] != 0 && kwt_len[s] <= 8 && kwt_kind[s] <= KW_KIND_MAX
          && !sc_toolong && sc_icount == kwt_len[s]) begin
        mask = kwt_len[s] == 8 ? '1 : ((64'd1 << (8 * kwt_len[s])) - 64'd1);
        if ((kwt_text[s] & mask) == sc_ibuf) k = K_KW0 + 6'(kwt_kind[s]);
      end
    end
    add_tok(k, sc_tstart, span24(sc_tstart, stop));
  endtask

  // close whatever token is open before position p
  task automatic close_open(input logic [23:0] p);
    logic [7:0]  sec;
    logic [5:0]  one, two;
    logic [23:0] dp;
    dp = p > 0 ? p - 24'd1 : 24'd0;
    case (sc_mode)
      M_PAIR: begin
        pair_kinds(sc_held, sec, one, two);
        add_tok(one, sc_tstart, 24'd1);
      end
      M_SLASH: add_tok(K_SLASH, sc_tstart, 24'd1);
      M_INT, M_FRAC: add_tok(K_NUMBER, sc_tstart, span24(sc_tstart, p));
      M_DOT: begin
        // number with a dangling dot splits into number then dot
        add_tok(K_NUMBER, sc_tstart, span24(sc_tstart, dp));
        sc_tstart = dp;
        add_tok(K_DOT, dp, 24'd1);
      end
      M_IDENT: add_word(p);
      default: ;
    endcase
    sc_mode = M_IDLE;
  endtask

  task automatic open_token(input logic [7:0] c, input logic [23:0] p);
    sc_tstart = p;
    sc_mode = M_IDLE;
    case (c)
      "(": add_tok(6'd0, p, 24'd1);
      ")": add_tok(6'd1, p, 24'd1);
      "[": add_tok(6'd4, p, 24'd1);
      "]": add_tok(6'd5, p, 24'd1);
      "@": add_tok(6'd6, p, 24'd1);
      ":": add_tok(6'd7, p, 24'd1);
      ";": add_tok(6'd8, p, 24'd1);
      ".": add_tok(K_DOT, p, 24'd1);
      "?": add_tok(6'd10, p, 24'd1);
      ",": add_tok(6'd11, p, 24'd1);
      "+": add_tok(6'd12, p, 24'd1);
      "-": add_tok(6'd13, p, 24'd1);
      "%": add_tok(6'd16, p, 24'd1);
      "{", "}", "*", "!", "=", "<", ">", "&", "|": begin
        sc_mode = M_PAIR; sc_held = c;
      end
      " ", 8'h0d, 8'h09: ;
      8'h0a: next_line();
      "/": sc_mode = M_SLASH;
      8'h22, 8'h27: begin
        sc_mode = M_STR; sc_held = c;
      end
      default: begin
        if (digit_ch(c)) sc_mode = M_INT;
        else if (letter_ch(c) || c == "_") begin
          sc_mode = M_IDENT; sc_ibuf = 64'(c); sc_icount = 4'd1; sc_toolong = 1'b0;
        end else add_tok(K_SYMBOL, p, 24'd1);
      end
    endcase
  endtask

  // one source byte; returns early while the byte stays inside the open token
  task automatic scan_byte(input logic [7:0] c, input logic [23:0] p);
    logic [7:0] sec;
    logic [5:0] one, two;
    case (sc_mode)
      M_PAIR: begin
        pair_kinds(sc_held, sec, one, two);
        if (c == sec) begin
          add_tok(two, sc_tstart, 24'd2); sc_mode = M_IDLE; return;
        end
      end
      M_SLASH: begin
        if (c == "/") begin sc_mode = M_LCOMM; return; end
        if (c == "*") begin sc_mode = M_BCOMM; return; end
      end
      M_LCOMM: begin
        if (c != 8'h0a) return;
        sc_mode = M_IDLE;
      end
      M_BCOMM: begin
        if (c == "*") sc_mode = M_BSTAR;
        else if (c == 8'h0a) next_line();
        return;
      end
      M_BSTAR: begin
        if (c == "/") sc_mode = M_IDLE;
        else if (c != "*") begin
          sc_mode = M_BCOMM;
          if (c == 8'h0a) next_line();
        end
        return;
      end
      M_STR: begin
        // string text excludes both quotes
        if (c == sc_held) begin
          add_tok(K_STRING, sc_tstart + 24'd1,
                  p > sc_tstart ? p - sc_tstart - 24'd1 : 24'd0);
          sc_mode = M_IDLE;
        end else if (c == 8'h0a) next_line();
        return;
      end
      M_INT: begin
        if (digit_ch(c)) return;
        if (c == ".") begin sc_mode = M_DOT; return; end
      end
      M_DOT: if (digit_ch(c)) begin sc_mode = M_FRAC; return; end
      M_FRAC: if (digit_ch(c)) return;
      M_IDENT: begin
        if (letter_ch(c) || digit_ch(c) || c == "_") begin
          if (sc_icount < 8) begin
            sc_ibuf |= 64'(c) << (8 * sc_icount);
            sc_icount++;
          end else sc_toolong = 1'b1;
          return;
        end
      end
      default: ;
    endcase
    close_open(p);
    open_token(c, p);
  endtask

  // works out the tokens caused by one accepted request
  task automatic predict_tokens(input lex_req_t r);
    step_toks.delete();
    case (r.cmd)
      CMD_BYTE: begin
        scan_byte(r.ch, sc_offset);
        if (sc_offset != 24'hffffff) sc_offset++;
      end
      CMD_END: begin
        close_open(sc_offset);
        add_tok(K_EOF, sc_tstart, 24'd0);
        clear_scan();
      end
      CMD_WRITE: begin
        kwt_text[r.slot] = r.text; kwt_len[r.slot] = r.len; kwt_kind[r.slot] = r.kind;
      end
      default: ;
    endcase
    if (step_toks.size() > 0) step_toks[step_toks.size() - 1].last = 1'b1;
    foreach (step_toks[i]) expected_toks.insert(expected_toks.size(), step_toks[i]);
  endtask

  // stimulus helpers
  function automatic logic [63:0] pack_word(string s);
    logic [63:0] v;
    v = 64'd0;
    for (int i = 0; i < s.len() && i < 8; i++) v |= 64'(s[i]) << (8 * i);
    return v;
  endfunction

  function automatic logic [7:0] word_ch();
    int k;
    k = $urandom_range(0, 62);
    if (k < 26) return 8'("a" + k);
    if (k < 52) return 8'("A" + k - 26);
    if (k < 62) return 8'("0" + k - 52);
    return "_";
  endfunction

  task automatic queue_req(input logic [1:0] cmd, input logic [7:0] ch, input logic [3:0] slot,
                           input logic [63:0] text, input logic [3:0] len,
                           input logic [3:0] kind);
    lex_req_t r;
    r.cmd = cmd; r.ch = ch; r.slot = slot; r.text = text; r.len = len; r.kind = kind;
    pending_reqs.insert(pending_reqs.size(), r);
  endtask

  task automatic queue_byte(input logic [7:0] c);
    queue_req(CMD_BYTE, c, 4'($urandom), {$urandom, $urandom}, 4'($urandom), 4'($urandom));
  endtask

  task automatic queue_text(input string s);
    for (int i = 0; i < s.len(); i++) queue_byte(s[i]);
  endtask

  task automatic queue_kw(input int slot, input string s, input int len, input int kind);
    queue_req(CMD_WRITE, 8'd0, 4'(slot), pack_word(s), 4'(len), 4'(kind));
  endtask

  string kw_pool[13] = '{"style", "script", "text", "use", "inherit", "from", "as",
                         "delete", "insert", "after", "before", "replace", "except"};
  string op_pool[20] = '{"{{", "}}", "==", "!=", "<=", ">=", "&&", "||", "**", "{", "}",
                         "(", ")", "[", "]", "@", ":", ";", "?", ","};

  // one well-formed fragment with random content, or the odd piece of noise
  task automatic queue_fragment();
    int    k, n;
    string s;
    k = $urandom_range(0, 99);
    if (k < 22) queue_text(kw_pool[$urandom_range(0, 12)]);
    else if (k < 36) begin
      n = $urandom_range(1, 11);
      s = "";
      queue_byte($urandom_range(0, 1) ? "_" : 8'("a" + $urandom_range(0, 25)));
      for (int i = 1; i < n; i++) queue_byte(word_ch());
    end else if (k < 46) begin
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++) queue_byte(8'("0" + $urandom_range(0, 9)));
      if ($urandom_range(0, 1)) queue_byte(".");
      if ($urandom_range(0, 1)) queue_byte(8'("0" + $urandom_range(0, 9)));
    end else if (k < 54) begin
      s = $urandom_range(0, 1) ? "\"" : "'";
      queue_text(s);
      n = $urandom_range(0, 4);
      for (int i = 0; i < n; i++) queue_byte($urandom_range(0, 9) == 0 ? 8'h0a : word_ch());
      if ($urandom_range(0, 7) != 0) queue_text(s);
    end else if (k < 68) queue_text(op_pool[$urandom_range(0, 19)]);
    else if (k < 72) queue_text($urandom_range(0, 1) ? "// x\n" : "/* a*\n**/");
    else if (k < 82) queue_text($urandom_range(0, 2) == 0 ? "\n" : " ");
    else if (k < 90) queue_byte(8'($urandom));
    else if (k < 94) queue_req(CMD_END, 8'($urandom), 4'($urandom), 64'd0, 4'd0, 4'd0);
    else if (k < 98) begin
      // table write: mostly real keywords, sometimes raw bits or odd lengths
      n = $urandom_range(0, 12);
      if ($urandom_range(0, 2) == 0)
        queue_req(CMD_WRITE, 8'd0, 4'($urandom), {$urandom, $urandom}, 4'($urandom),
                  4'($urandom));
      else queue_kw($urandom_range(0, 15), kw_pool[n], kw_pool[n].len(),
                    $urandom_range(0, 12));
    end else queue_req(CMD_SPARE, 8'($urandom), 4'($urandom), {$urandom, $urandom},
                       4'($urandom), 4'($urandom));
  endtask

  // driver: new request and pop decision on the falling edge
  always @(negedge clk) begin
    int phase, tx_idle, rx_idle;
    phase = n_sent < N_ITEMS / 3 ? 0 : (n_sent < 2 * N_ITEMS / 3 ? 1 : 2);
    tx_idle = phase == 0 ? 23 : (phase == 1 ? 55 : 0);
    rx_idle = phase == 0 ? 55 : (phase == 1 ? 23 : 0);
    if (req_taken) begin
      void'(pending_reqs.pop_front());
      req_taken = 1'b0;
    end
    if (!rst && pending_reqs.size() > 0 && $urandom_range(0, 99) >= tx_idle) begin
      push      <= 1'b1;
      command   <= pending_reqs[0].cmd;
      char_code <= pending_reqs[0].ch;
      kw_slot   <= pending_reqs[0].slot;
      kw_text   <= pending_reqs[0].text;
      kw_length <= pending_reqs[0].len;
      kw_kind   <= pending_reqs[0].kind;
    end else push <= 1'b0;
    pop <= !rst && $urandom_range(0, 99) >= rx_idle;
  end

  // monitor: requests and tokens accepted on the rising edge
  always @(posedge clk) begin
    lex_tok_t e;
    bit       moved;
    moved = 1'b0;
    if (!rst && push && !full) begin
      predict_tokens(pending_reqs[0]);
      req_taken = 1'b1;
      n_sent++;
      moved = 1'b1;
    end
    if (!rst && pop && !empty) begin
      moved = 1'b1;
      if (expected_toks.size() == 0) begin
        $display("%0t: token with none expected, kind %0d start %0d", $realtime,
                 token_kind, text_start);
        n_errors++;
      end else begin
        e = expected_toks.pop_front();
        if (token_kind !== e.kind || text_start !== e.start || text_length !== e.length ||
            line_number !== e.line || last_of_run !== e.last) begin
          $display("%0t: token mismatch, expected kind %0d start %0d len %0d line %0d last %0d",
                   $realtime, e.kind, e.start, e.length, e.line, e.last);
          $display("%0t:                   actual kind %0d start %0d len %0d line %0d last %0d",
                   $realtime, token_kind, text_start, text_length, line_number, last_of_run);
          n_errors++;
        end
      end
    end
    // watchdog on cycles with no traffic either side
    quiet_cycles = moved ? 0 : quiet_cycles + 1;
    if (quiet_cycles >= WD_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    clear_scan();
    for (int s = 0; s < 16; s++) begin
      kwt_text[s] = 64'd0; kwt_len[s] = 4'd0; kwt_kind[s] = 4'd0;
    end
    // directed: duplicate slot, eight-byte keyword, bad length and bad kind slots
    queue_kw(0, "style", 5, 0);
    queue_kw(1, "as", 2, 6);
    queue_kw(2, "as", 2, 7);
    queue_kw(15, "replaces", 8, 11);
    queue_kw(3, "from", 9, 5);
    queue_kw(4, "text", 4, 13);
    queue_text("style as replaces text from abcdefghi {{}}==!=<=>=&&||**3.14 7.x");
    queue_text(" \"ab\n\"'c'//z\n/* **\n*/");
    queue_byte(8'hff); queue_byte(8'h00); queue_byte(8'h7f); queue_byte("/");
    queue_req(CMD_END, 8'd0, 4'd0, 64'd0, 4'd0, 4'd0);
    queue_req(CMD_END, 8'd0, 4'd0, 64'd0, 4'd0, 4'd0);
    queue_text("\"open");
    queue_req(CMD_END, 8'd0, 4'd0, 64'd0, 4'd0, 4'd0);
    queue_req(CMD_SPARE, 8'hff, 4'hf, '1, 4'hf, 4'hf);
    queue_kw(1, "", 0, 0);
    // random part: mostly well-formed fragments
    while (pending_reqs.size() < N_ITEMS) queue_fragment();
    queue_req(CMD_END, 8'd0, 4'd0, 64'd0, 4'd0, 4'd0);

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    while (pending_reqs.size() > 0 || expected_toks.size() > 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (n_errors == 0 && expected_toks.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
`default_nettype wire
